>>> design/assert_macros.svh
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

>>> design/pvfl_pkg.sv
// Shared types and constants of the velocity regulator.
package pvfl_pkg;

	localparam int FRACTION_SCALE = 16;
	localparam int DATA_W = 16;
	localparam int DIV_W = 9;

	localparam logic [DATA_W-1:0] FS_MUL = DATA_W'(FRACTION_SCALE);

	// division by the fraction scale: magnitude times a rounded-up reciprocal,
	// exact for every 16-bit magnitude
	localparam int FS_SHIFT = DATA_W + $clog2(FRACTION_SCALE);
	localparam int RECIP_W = FS_SHIFT + 1;
	localparam logic [RECIP_W-1:0] FS_RECIP =
		RECIP_W'(((64'd1 << FS_SHIFT) + 64'(FRACTION_SCALE - 1)) / 64'(FRACTION_SCALE));

	// register indexes
	localparam logic [2:0] CFG_PROP_GAIN    = 3'd0;
	localparam logic [2:0] CFG_INTEG_GAIN   = 3'd1;
	localparam logic [2:0] CFG_DERIV_GAIN   = 3'd2;
	localparam logic [2:0] CFG_FEEDFWD_GAIN = 3'd3;
	localparam logic [2:0] CFG_INTEG_CLAMP  = 3'd4;
	localparam logic [2:0] CFG_SPEED_CAP    = 3'd5;
	localparam logic [2:0] CFG_OUT_NUM      = 3'd6;
	localparam logic [2:0] CFG_OUT_DEN      = 3'd7;

	// reset values
	localparam logic [7:0] RST_PROP_GAIN     = 8'd4;
	localparam logic [7:0] RST_INTEG_GAIN    = 8'd1;
	localparam logic [7:0] RST_DERIV_GAIN    = 8'd0;
	localparam logic [7:0] RST_FEEDFWD_GAIN  = 8'd1;
	localparam logic [14:0] RST_INTEG_CLAMP  = 15'd1600;
	localparam logic [14:0] RST_SPEED_CAP    = 15'd100;
	localparam logic [7:0] RST_OUT_NUM       = 8'd17;
	localparam logic [7:0] RST_OUT_DEN       = 8'd4;

	typedef struct packed {
		logic [7:0]  prop_gain;
		logic [7:0]  integ_gain;
		logic [7:0]  deriv_gain;
		logic [7:0]  feedfwd_gain;
		logic [14:0] integ_clamp;
		logic [14:0] speed_cap;
		logic [7:0]  out_num;
		logic [7:0]  out_den;
	} cfg_t;

	typedef struct packed {
		logic set_speed;
		logic capture;
		logic step_e;
		logic step_p;
		logic step_i;
		logic step_sum;
		logic step_scale;
		logic div_start_den;
		logic take_t;
		logic step_mul;
		logic take_o;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic div_done;
	} sts_t;

endpackage

>>> design/pvfl_div.sv
// Restoring divider, one quotient bit per cycle, unsigned operands.
module pvfl_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [pvfl_pkg::DATA_W-1:0] dividend,
	input  logic [pvfl_pkg::DIV_W-1:0]  divisor,
	output logic                        done,
	output logic [pvfl_pkg::DATA_W-1:0] quotient
);
	import pvfl_pkg::*;

	localparam int CNT_W = $clog2(DATA_W);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DATA_W - 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DIV_W-1:0] rem_q;
	logic [DIV_W-1:0] dvs_q;
	logic [DATA_W-1:0] quo_q;

	logic [DIV_W:0]   trial;
	logic [DIV_W:0]   diff;
	logic             ge;

	assign trial = {rem_q, quo_q[DATA_W-1]};
	assign ge    = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
			quo_q <= {quo_q[DATA_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

>>> design/pvfl_dp.sv
// Datapath: loop state, term registers, divider and result register.
module pvfl_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  pvfl_pkg::cfg_t              cfg,
	input  pvfl_pkg::cmd_t              cmd,
	output pvfl_pkg::sts_t              sts,
	input  logic [pvfl_pkg::DATA_W-1:0] in_req,
	input  logic [pvfl_pkg::DATA_W-1:0] in_meas,
	output logic [7:0]                  out_mag,
	output logic                        out_fwd
);
	import pvfl_pkg::*;

	// symmetric clamp of a 16-bit signed value
	function automatic logic [DATA_W-1:0] clamp_sym(logic [DATA_W-1:0] v, logic [14:0] lim);
		logic signed [DATA_W:0] vs;
		logic signed [DATA_W:0] ls;
		logic signed [DATA_W:0] nl;
		logic [DATA_W-1:0]      r;
		vs = signed'({v[DATA_W-1], v});
		ls = signed'({2'b00, lim});
		nl = -ls;
		r  = v;
		if (!v[DATA_W-1]) begin
			if (vs > ls)
				r = ls[DATA_W-1:0];
		end else begin
			if (vs < nl)
				r = nl[DATA_W-1:0];
		end
		return r;
	endfunction

	// loop state
	logic [DATA_W-1:0] req_q;
	logic [DATA_W-1:0] integ_q;
	logic [DATA_W-1:0] prev_q;

	// working registers
	logic [DATA_W-1:0] meas_q;
	logic [DATA_W-1:0] e_q;
	logic [DATA_W-1:0] ff_q;
	logic [DATA_W-1:0] ie_q;
	logic [DATA_W-1:0] p_q;
	logic [DATA_W-1:0] d_q;
	logic [DATA_W-1:0] f_q;
	logic [DATA_W-1:0] sum_q;
	logic              neg_q;
	logic [DATA_W-1:0] scl_q;
	logic [DATA_W-1:0] t_q;
	logic [DATA_W-1:0] prod_q;
	logic [DATA_W-1:0] o_q;
	logic [7:0]        mag_q;
	logic              fwd_q;

	logic [DATA_W-1:0]         set_val;
	logic [DATA_W-1:0]         err_diff;
	logic [2*DATA_W-1:0]       e_prod;
	logic [DATA_W+7:0]         ff_prod;
	logic [DATA_W+7:0]         ie_prod;
	logic [DATA_W+7:0]         p_prod;
	logic [DATA_W-1:0]         pd_diff;
	logic [DATA_W+7:0]         d_prod;
	logic [2*DATA_W-1:0]       f_prod;
	logic [DATA_W+7:0]         m_prod;
	logic [DATA_W-1:0]         sum_mag;
	logic [DATA_W+RECIP_W-1:0] scl_prod;
	logic [DATA_W-1:0]         t_res;
	logic [DATA_W-1:0]         div_mag;
	logic [DIV_W-1:0]          den_eff;
	logic                      div_start;
	logic                      div_done;
	logic [DATA_W-1:0]         div_quo;
	logic [DATA_W-1:0]         div_res;
	logic [DATA_W-1:0]         o_mag;

	assign set_val  = clamp_sym(in_req, cfg.speed_cap);
	assign err_diff = req_q - meas_q;
	assign e_prod   = err_diff * FS_MUL;
	assign ff_prod  = req_q * cfg.feedfwd_gain;
	assign ie_prod  = e_q * cfg.integ_gain;
	assign p_prod   = e_q * cfg.prop_gain;
	assign pd_diff  = prev_q - e_q;
	assign d_prod   = pd_diff * cfg.deriv_gain;
	assign f_prod   = ff_q * FS_MUL;
	assign m_prod   = t_q * cfg.out_num;

	// sum over the fraction scale, truncating toward zero
	assign sum_mag  = sum_q[DATA_W-1] ? (~sum_q + 1'b1) : sum_q;
	assign scl_prod = sum_mag * FS_RECIP;
	assign t_res    = neg_q ? (~scl_q + 1'b1) : scl_q;

	// divider: scaled output over out_den
	assign den_eff   = (cfg.out_den == 8'd0) ? DIV_W'(1) : {1'b0, cfg.out_den};
	assign div_mag   = prod_q[DATA_W-1] ? (~prod_q + 1'b1) : prod_q;
	assign div_start = cmd.div_start_den;
	assign div_res   = neg_q ? (~div_quo + 1'b1) : div_quo;

	assign o_mag = o_q[DATA_W-1] ? (~o_q + 1'b1) : o_q;

	pvfl_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_mag),
		.divisor  (den_eff),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign sts.div_done = div_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_q   <= '0;
			integ_q <= '0;
			prev_q  <= '0;
		end else begin
			if (cmd.set_speed) begin
				if (req_q[DATA_W-1] != set_val[DATA_W-1])
					integ_q <= '0;
				prev_q <= '0;
				req_q  <= set_val;
			end
			if (cmd.step_i) begin
				integ_q <= clamp_sym(integ_q + ie_q, cfg.integ_clamp);
				prev_q  <= e_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture)
			meas_q <= in_meas;
		if (cmd.step_e) begin
			e_q  <= e_prod[DATA_W-1:0];
			ff_q <= ff_prod[DATA_W-1:0];
		end
		if (cmd.step_p) begin
			ie_q <= ie_prod[DATA_W-1:0];
			p_q  <= p_prod[DATA_W-1:0];
		end
		if (cmd.step_i) begin
			d_q <= d_prod[DATA_W-1:0];
			f_q <= f_prod[DATA_W-1:0];
		end
		if (cmd.step_sum)
			sum_q <= p_q + integ_q + d_q + f_q;
		// sign of the value being divided, for the sum and then the output
		if (cmd.step_scale)
			neg_q <= sum_q[DATA_W-1];
		else if (div_start)
			neg_q <= prod_q[DATA_W-1];
		if (cmd.step_scale)
			scl_q <= scl_prod[FS_SHIFT +: DATA_W];
		if (cmd.take_t)
			t_q <= t_res;
		if (cmd.step_mul)
			prod_q <= m_prod[DATA_W-1:0];
		if (cmd.take_o)
			o_q <= div_res;
		if (cmd.load_out) begin
			fwd_q <= ~o_q[DATA_W-1];
			mag_q <= (|o_mag[DATA_W-1:8]) ? 8'hFF : o_mag[7:0];
		end
	end

	assign out_mag = mag_q;
	assign out_fwd = fwd_q;

endmodule

>>> design/pvfl_ctrl.sv
// Controller: sequences one control step and owns the input and output handshakes.
module pvfl_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           in_op,
	input  logic           in_fresh,
	output logic           in_ready,
	input  logic           out_ready,
	output logic           out_valid,
	output pvfl_pkg::cmd_t cmd,
	input  pvfl_pkg::sts_t sts
);
	import pvfl_pkg::*;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_ERR   = 4'd1;
	localparam logic [3:0] ST_PROP  = 4'd2;
	localparam logic [3:0] ST_INTG  = 4'd3;
	localparam logic [3:0] ST_SUM   = 4'd4;
	localparam logic [3:0] ST_SCALE = 4'd5;
	localparam logic [3:0] ST_TAKE  = 4'd6;
	localparam logic [3:0] ST_MUL   = 4'd7;
	localparam logic [3:0] ST_STA2  = 4'd8;
	localparam logic [3:0] ST_DIV2  = 4'd9;
	localparam logic [3:0] ST_OUT   = 4'd10;

	logic [3:0] state_q;
	logic [3:0] state_nxt;
	logic       out_valid_q;

	always_comb begin
		cmd       = '0;
		in_ready  = 1'b0;
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (!in_op) begin
						cmd.set_speed = 1'b1;
					end else if (in_fresh) begin
						cmd.capture = 1'b1;
						state_nxt   = ST_ERR;
					end
				end
			end
			ST_ERR: begin
				cmd.step_e = 1'b1;
				state_nxt  = ST_PROP;
			end
			ST_PROP: begin
				cmd.step_p = 1'b1;
				state_nxt  = ST_INTG;
			end
			ST_INTG: begin
				cmd.step_i = 1'b1;
				state_nxt  = ST_SUM;
			end
			ST_SUM: begin
				cmd.step_sum = 1'b1;
				state_nxt    = ST_SCALE;
			end
			ST_SCALE: begin
				cmd.step_scale = 1'b1;
				state_nxt      = ST_TAKE;
			end
			ST_TAKE: begin
				cmd.take_t = 1'b1;
				state_nxt  = ST_MUL;
			end
			ST_MUL: begin
				cmd.step_mul = 1'b1;
				state_nxt    = ST_STA2;
			end
			ST_STA2: begin
				cmd.div_start_den = 1'b1;
				state_nxt         = ST_DIV2;
			end
			ST_DIV2: begin
				if (sts.div_done) begin
					cmd.take_o = 1'b1;
					state_nxt  = ST_OUT;
				end
			end
			ST_OUT: begin
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_nxt    = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.load_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

>>> design/velocity_pid_feedforward_loop_top.sv
// Wheel velocity regulator: PID with feedforward and saturating integrator.
// One beat in on s_* is either a set-speed request (no result), a stale control
// tick (no result) or a fresh control tick, which yields one sign-magnitude
// drive beat on m_*; the next input beat is taken only after that result is in
// the output register. Most of the time goes to the restoring divider, which
// retires one quotient bit per cycle, for the scaled output over out_den. The
// division by the fraction scale is a reciprocal multiply; it and the remaining
// steps each occupy one state of the sequencer.
// s_tready is low while a tick is being worked on. A finished result sits in
// the output register, so the next beat is taken while it waits for m_tready.
// Configuration writes take effect at once and belong in idle periods.
module velocity_pid_feedforward_loop_top (
	input  logic        clk,
	input  logic        arst_n,
	// input beats
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // requested_speed[15:0], measured_speed[31:16]
	input  logic [1:0]  s_tuser,   // operation[0], measurement_fresh[1]
	// result beats
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // drive_magnitude[7:0], drive_forward[8], zero[15:9]
	// register writes
	input  logic        cfg_we,
	input  logic [2:0]  cfg_addr,
	input  logic [14:0] cfg_data
);
	import pvfl_pkg::*;

	cfg_t       cfg_q;
	cmd_t       cmd;
	sts_t       sts;
	logic [7:0] drv_mag;
	logic       drv_fwd;

	// register file; 8-bit registers take the low byte of the write data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prop_gain    <= RST_PROP_GAIN;
			cfg_q.integ_gain   <= RST_INTEG_GAIN;
			cfg_q.deriv_gain   <= RST_DERIV_GAIN;
			cfg_q.feedfwd_gain <= RST_FEEDFWD_GAIN;
			cfg_q.integ_clamp  <= RST_INTEG_CLAMP;
			cfg_q.speed_cap    <= RST_SPEED_CAP;
			cfg_q.out_num      <= RST_OUT_NUM;
			cfg_q.out_den      <= RST_OUT_DEN;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				CFG_PROP_GAIN:    cfg_q.prop_gain    <= cfg_data[7:0];
				CFG_INTEG_GAIN:   cfg_q.integ_gain   <= cfg_data[7:0];
				CFG_DERIV_GAIN:   cfg_q.deriv_gain   <= cfg_data[7:0];
				CFG_FEEDFWD_GAIN: cfg_q.feedfwd_gain <= cfg_data[7:0];
				CFG_INTEG_CLAMP:  cfg_q.integ_clamp  <= cfg_data;
				CFG_SPEED_CAP:    cfg_q.speed_cap    <= cfg_data;
				CFG_OUT_NUM:      cfg_q.out_num      <= cfg_data[7:0];
				CFG_OUT_DEN:      cfg_q.out_den      <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// sequencer: handshakes and step commands
	pvfl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_op     (s_tuser[0]),
		.in_fresh  (s_tuser[1]),
		.in_ready  (s_tready),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.cmd       (cmd),
		.sts       (sts)
	);

	// arithmetic, loop state and result register
	pvfl_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.cmd     (cmd),
		.sts     (sts),
		.in_req  (s_tdata[15:0]),
		.in_meas (s_tdata[31:16]),
		.out_mag (drv_mag),
		.out_fwd (drv_fwd)
	);

	assign m_tdata = {7'b0, drv_fwd, drv_mag};

endmodule

>>> design/pvfl_chk.sv
// Port-level checker for the velocity regulator, bound to the top level.
`include "assert_macros.svh"

module pvfl_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [1:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata
);

	// a stalled result beat stays and holds its data
	`ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

	// a fresh tick occupies the block: no beat is taken in the next cycle
	`ASSERT_NEXT(a_tick_busy, s_tvalid && s_tready && s_tuser[0] && s_tuser[1], !s_tready)

	// a set-speed beat taken while no result is pending does not raise m_tvalid
	`ASSERT_NEXT(a_set_silent, s_tvalid && s_tready && !s_tuser[0] && !m_tvalid, !m_tvalid)

	// pad bits of the result stay zero
	`ASSERT_SAME(a_out_pad, m_tvalid, m_tdata[15:9] == 7'd0)

endmodule

bind velocity_pid_feedforward_loop_top pvfl_chk u_pvfl_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
